// ----- src/hds_pkg.sv -----
// ----------------------------------------------------------------------------
// hds_pkg
// Types, constants and tables shared by the direction sampler modules.
// ----------------------------------------------------------------------------
package hds_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int U_BITS          = 24;
	localparam int CW              = 34;
	localparam int CORDIC_STEPS    = 30;
	localparam int LOG_STEPS       = 30;
	localparam int DIV_STEPS       = 37;
	localparam int SQRT_STEPS      = 31;

	localparam logic [15:0]        ROUGH_RESET     = 16'd4096;
	localparam logic [32:0]        TWO_PI_Q30      = 33'd6746518852;
	localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
	localparam logic [27:0]        LN2_Q28         = 28'd186065280;

	typedef enum logic [1:0] {
		MODE_UNIFORM  = 2'd0,
		MODE_COSINE   = 2'd1,
		MODE_BECKMANN = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] u_first;
		logic [15:0] u_second;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} direction_t;

	typedef struct packed {
		logic [1:0]           quad;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic [4:0]  k;
		logic [30:0] m;
		logic [29:0] frac;
	} log_t;

	typedef struct packed {
		logic [60:0] rem;
		logic [37:0] den;
		logic [36:0] quo;
	} div_t;

	typedef struct packed {
		logic [60:0] rem;
		logic [30:0] root;
	} sqrt_t;

	// arctangent of 2^-step in q4.30 radians
	function automatic logic signed [CW-1:0] atan_q30(input int step);
		logic signed [CW-1:0] a;
		case (step)
			0:       a = 34'sd843314857;
			1:       a = 34'sd497837829;
			2:       a = 34'sd263043837;
			3:       a = 34'sd133525159;
			4:       a = 34'sd67021687;
			5:       a = 34'sd33543516;
			6:       a = 34'sd16775851;
			7:       a = 34'sd8388437;
			8:       a = 34'sd4194283;
			9:       a = 34'sd2097149;
			default: a = CW'(1) <<< (30 - step);
		endcase
		return a;
	endfunction

endpackage

// ----- src/hds_delay.sv -----
// ----------------------------------------------------------------------------
// hds_delay
// Shift line that keeps side data aligned with the arithmetic cells.
// ----------------------------------------------------------------------------
module hds_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];
endmodule

// ----- src/hds_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// hds_cordic_cell
// One rotation step of the azimuth cordic.
// ----------------------------------------------------------------------------
module hds_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic             clk,
	input  logic             en,
	input  hds_pkg::cordic_t d,
	output hds_pkg::cordic_t q
);
	import hds_pkg::*;

	logic signed [CW-1:0] a;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	cordic_t nxt;

	always_comb begin
		a        = atan_q30(STEP);
		dx       = d.y >>> STEP;
		dy       = d.x >>> STEP;
		nxt.quad = d.quad;
		if (!d.z[CW-1]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - a;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// ----- src/hds_log_cell.sv -----
// ----------------------------------------------------------------------------
// hds_log_cell
// One fraction bit of log2 by squaring the mantissa.
// ----------------------------------------------------------------------------
module hds_log_cell (
	input  logic          clk,
	input  logic          en,
	input  hds_pkg::log_t d,
	output hds_pkg::log_t q
);
	import hds_pkg::*;

	logic [61:0] sq;
	logic [31:0] t;
	log_t nxt;

	always_comb begin
		sq    = 62'(d.m) * 62'(d.m);
		t     = sq[61:30];
		nxt.k = d.k;
		if (t[31]) begin
			nxt.m    = t[31:1];
			nxt.frac = {d.frac[28:0], 1'b1};
		end else begin
			nxt.m    = t[30:0];
			nxt.frac = {d.frac[28:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// ----- src/hds_div_cell.sv -----
// ----------------------------------------------------------------------------
// hds_div_cell
// One quotient bit of the restoring divider for the squared cosine.
// ----------------------------------------------------------------------------
module hds_div_cell #(
	parameter int K = 0
) (
	input  logic          clk,
	input  logic          en,
	input  hds_pkg::div_t d,
	output hds_pkg::div_t q
);
	import hds_pkg::*;

	logic [74:0] shifted;
	div_t nxt;

	always_comb begin
		shifted = 75'(d.den) << K;
		nxt     = d;
		if ({14'd0, d.rem} >= shifted) begin
			nxt.rem = d.rem - shifted[60:0];
			nxt.quo = d.quo | (37'(1) << K);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// ----- src/hds_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// hds_sqrt_cell
// One root bit of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module hds_sqrt_cell #(
	parameter int K = 0
) (
	input  logic           clk,
	input  logic           en,
	input  hds_pkg::sqrt_t d,
	output hds_pkg::sqrt_t q
);
	import hds_pkg::*;

	logic [62:0] trial;
	sqrt_t nxt;

	// remainder holds v - root^2, trial is (root + 2^k)^2 - root^2
	always_comb begin
		trial = (63'(d.root) << (K + 1)) + (63'(1) << (2 * K));
		nxt   = d;
		if ({2'd0, d.rem} >= trial) begin
			nxt.rem  = d.rem - trial[60:0];
			nxt.root = d.root | (31'(1) << K);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// ----- src/hemisphere_direction_sampler.sv -----
// ----------------------------------------------------------------------------
// hemisphere_direction_sampler
// Maps two uniform samples to a tangent-space unit direction.
// ----------------------------------------------------------------------------
// Fully pipelined: one sample transaction is taken every cycle unless the
// pipeline halts, and its direction passes through 103 pipeline levels plus the
// output register. The depth is set by the longest row of cells: 30 log2 cells,
// 37 divider cells and 31 square-root cells on the Beckmann path; the cordic
// and the side data are delayed to meet it. The pipeline only halts when its
// last level holds a result and the output register is full and stalled.
// The user writes roughness through the cfg channel only while no transaction is
// in flight; the block does not enforce this. cfg_ready is always high.
module hemisphere_direction_sampler #(
	parameter int SAMPLE_BITS = hds_pkg::SAMPLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  hds_pkg::sample_t    sample,
	output logic                direction_valid,
	input  logic                direction_stall,
	output hds_pkg::direction_t direction,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import hds_pkg::*;

	localparam int L_LN     = LOG_STEPS + 1;
	localparam int L_TAN    = L_LN + 1;
	localparam int L_OP     = L_TAN + DIV_STEPS + 1;
	localparam int L_SQ     = L_OP + SQRT_STEPS;
	localparam int L_PR     = L_SQ + 1;
	localparam int CS_DEPTH = L_SQ - (CORDIC_STEPS + 1);
	localparam int SB_DEPTH = L_OP - 1;
	localparam int U_SHIFT  = U_BITS - SAMPLE_BITS;
	localparam logic [U_BITS-1:0] U_MASK = U_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

	typedef struct packed {
		logic [1:0]        mode;
		logic [U_BITS-1:0] u;
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] s;
	} cs_t;

	logic        en;
	logic [L_PR:0] vld_q;
	logic        out_vld_q;
	direction_t  dir_q;
	logic [15:0] rough_q;
	logic [31:0] rsq_q;

	// front level
	logic [U_BITS-1:0] u_raw, t_raw, u_w, t_w, uc_w;
	logic [4:0]        k;
	logic [54:0]       zprod;
	side_t             side_s0;
	log_t              log_s0;
	cordic_t           cor_s0;

	always_comb begin
		u_raw = U_BITS'(sample.u_first) & U_MASK;
		t_raw = U_BITS'(sample.u_second) & U_MASK;
		u_w   = u_raw << U_SHIFT;
		t_w   = t_raw << U_SHIFT;
		// zero is clamped to the smallest code for the log
		uc_w  = ((u_raw == '0) ? U_BITS'(1) : u_raw) << U_SHIFT;
		k     = '0;
		for (int i = 0; i < U_BITS; i++) begin
			if (uc_w[i]) begin
				k = 5'(i);
			end
		end
		zprod = 55'(t_w[21:0]) * 55'(TWO_PI_Q30);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s0.mode <= sample.mode;
			side_s0.u    <= u_w;
			log_s0.k     <= k;
			log_s0.m     <= 31'(uc_w) << (5'd30 - k);
			log_s0.frac  <= '0;
			cor_s0.quad  <= t_w[23:22];
			cor_s0.x     <= CORDIC_GAIN_INV;
			cor_s0.y     <= '0;
			cor_s0.z     <= CW'(zprod[54:24]);
		end
	end

	// log2 cells
	log_t log_c [LOG_STEPS+1];
	assign log_c[0] = log_s0;
	for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
		hds_log_cell u_cell (.clk(clk), .en(en), .d(log_c[g]), .q(log_c[g+1]));
	end

	// natural log and tan^2
	logic [34:0] nl2;
	logic [62:0] nln_prod;
	logic [20:0] tin_q;
	logic [52:0] tprod;
	div_t        div_s0;

	always_comb begin
		nl2      = (35'(5'd24 - log_c[LOG_STEPS].k) << 30) - 35'(log_c[LOG_STEPS].frac);
		nln_prod = 63'(nl2) * 63'(LN2_Q28);
		tprod    = 53'(rsq_q) * 53'(tin_q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tin_q       <= nln_prod[62:42];
			div_s0.rem  <= 61'(1) << 60;
			div_s0.den  <= 38'(tprod[52:16]) + (38'(1) << 24);
			div_s0.quo  <= '0;
		end
	end

	// divider cells
	div_t div_c [DIV_STEPS+1];
	assign div_c[0] = div_s0;
	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		hds_div_cell #(.K(DIV_STEPS - 1 - g)) u_cell (
			.clk(clk), .en(en), .d(div_c[g]), .q(div_c[g+1])
		);
	end

	side_t side_d;
	hds_delay #(.W($bits(side_t)), .DEPTH(SB_DEPTH)) u_side_dly (
		.clk(clk), .en(en), .d(side_s0), .q(side_d)
	);

	// square-root operands per mode
	logic [29:0] yq;
	logic [59:0] yq2;
	logic [60:0] yop, sop;
	sqrt_t       ysq_s0, ssq_s0;

	always_comb begin
		yq  = 30'(side_d.u) << 6;
		yq2 = 60'(yq) * 60'(yq);
		case (mode_t'(side_d.mode))
			MODE_COSINE: begin
				sop = 61'(side_d.u) << 36;
				yop = 61'(25'(1 << U_BITS) - 25'(side_d.u)) << 36;
			end
			MODE_BECKMANN: begin
				yop = 61'(div_c[DIV_STEPS].quo) << 24;
				sop = (61'(1) << 60) - yop;
			end
			default: begin
				yop = 61'(yq2);
				sop = (61'(1) << 60) - 61'(yq2);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ysq_s0.rem  <= yop;
			ysq_s0.root <= '0;
			ssq_s0.rem  <= sop;
			ssq_s0.root <= '0;
		end
	end

	// two square-root rows
	sqrt_t ysq_c [SQRT_STEPS+1];
	sqrt_t ssq_c [SQRT_STEPS+1];
	assign ysq_c[0] = ysq_s0;
	assign ssq_c[0] = ssq_s0;
	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		hds_sqrt_cell #(.K(SQRT_STEPS - 1 - g)) u_ycell (
			.clk(clk), .en(en), .d(ysq_c[g]), .q(ysq_c[g+1])
		);
		hds_sqrt_cell #(.K(SQRT_STEPS - 1 - g)) u_scell (
			.clk(clk), .en(en), .d(ssq_c[g]), .q(ssq_c[g+1])
		);
	end

	// azimuth cordic
	cordic_t cor_c [CORDIC_STEPS+1];
	assign cor_c[0] = cor_s0;
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		hds_cordic_cell #(.STEP(g)) u_cell (
			.clk(clk), .en(en), .d(cor_c[g]), .q(cor_c[g+1])
		);
	end

	cordic_t cor_end;
	cs_t     cs_q, cs_d;
	assign cor_end = cor_c[CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			case (cor_end.quad)
				2'd0: begin
					cs_q.c <= cor_end.x;
					cs_q.s <= cor_end.y;
				end
				2'd1: begin
					cs_q.c <= -cor_end.y;
					cs_q.s <= cor_end.x;
				end
				2'd2: begin
					cs_q.c <= -cor_end.x;
					cs_q.s <= -cor_end.y;
				end
				default: begin
					cs_q.c <= cor_end.y;
					cs_q.s <= -cor_end.x;
				end
			endcase
		end
	end

	hds_delay #(.W($bits(cs_t)), .DEPTH(CS_DEPTH)) u_cs_dly (
		.clk(clk), .en(en), .d(cs_q), .q(cs_d)
	);

	// products
	logic signed [31:0] s_sg;
	logic signed [65:0] px_s, pz_s;
	logic [30:0]        yr_s;

	assign s_sg = $signed({1'b0, ssq_c[SQRT_STEPS].root});

	always_ff @(posedge clk) begin
		if (en) begin
			px_s <= 66'(s_sg) * 66'(cs_d.c);
			pz_s <= 66'(s_sg) * 66'(cs_d.s);
			yr_s <= ysq_c[SQRT_STEPS].root;
		end
	end

	// rounding and saturation
	function automatic logic signed [15:0] sat_prod(input logic signed [65:0] p);
		logic signed [65:0] r;
		logic signed [20:0] v;
		r = p + (66'sd1 <<< 44);
		v = r[65:45];
		if (v > 21'sd32767) begin
			return 16'sd32767;
		end else if (v < -21'sd32768) begin
			return -16'sd32768;
		end
		return v[15:0];
	endfunction

	logic [31:0]  y_rnd;
	direction_t   dir_nxt;

	always_comb begin
		y_rnd         = (32'(yr_s) + 32'd16384) >> 15;
		dir_nxt.dir_x = sat_prod(px_s);
		dir_nxt.dir_z = sat_prod(pz_s);
		dir_nxt.dir_y = (y_rnd > 32'd32767) ? 16'sd32767 : $signed(y_rnd[15:0]);
	end

	// pipeline flow
	assign en           = !(out_vld_q && direction_stall && vld_q[L_PR]);
	assign sample_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L_PR-1:0], sample_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || !direction_stall) begin
			out_vld_q <= vld_q[L_PR];
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !direction_stall) begin
			dir_q <= dir_nxt;
		end
	end

	assign direction_valid = out_vld_q;
	assign direction       = dir_q;

	// roughness register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rough_q <= ROUGH_RESET;
		end else if (cfg_valid) begin
			rough_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		rsq_q <= 32'(rough_q) * 32'(rough_q);
	end
endmodule

// ----- bench/tb_hemisphere_direction_sampler.sv -----
// ----------------------------------------------------------------------------
// tb_hemisphere_direction_sampler
// Streams sample transactions through the direction sampler under random
// valid gaps and output stalls, predicts every direction with a bit-exact
// integer model and checks each output transaction in order. Roughness is
// rewritten between phases while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_hemisphere_direction_sampler;

	import hds_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, acts as uniform
	localparam int         LIMIT      = 1000000;
	localparam int         DRAIN      = 200;
	localparam int         PHASES     = 8;
	localparam int         PHASE_LEN  = 205;

	logic       clk;
	logic       arst_n;
	logic       sample_valid;
	logic       sample_stall;
	sample_t    sample;
	logic       direction_valid;
	logic       direction_stall;
	direction_t direction;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [15:0] cfg_data;

	sample_t     pending_q[$];
	direction_t  expected_dir_q[$];
	logic [15:0] rough_write_q[$];
	logic [15:0] rough_model;
	int          rough_writes;
	int          send_gap;
	int          stall_left;
	int          cycles;
	int          errors;
	bit          calm;

	hemisphere_direction_sampler dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample          (sample),
		.direction_valid (direction_valid),
		.direction_stall (direction_stall),
		.direction       (direction),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] sat16(longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic direction_t predict_direction(sample_t s, logic [15:0] rough);
		longint unsigned u, t, r, yq, sq, uc, nl2, nln, tan2, c2, m, frac;
		longint x, y, z, a, dx, dy, cphi, sphi;
		int k, i;
		logic [1:0] q;
		direction_t d;
		u = longint'(s.u_first) << 8;
		t = longint'(s.u_second) << 8;
		if (s.mode == MODE_COSINE) begin
			sq = isqrt(u << 36);
			yq = isqrt(((64'd1 << 24) - u) << 36);
		end else if (s.mode == MODE_BECKMANN) begin
			// zero sample is clamped to the smallest code
			uc = (s.u_first == 16'd0) ? 64'd256 : u;
			k = 0;
			while (k < 23 && (uc >> (k + 1)) != 0)
				k++;
			m = uc << (30 - k);
			frac = 0;
			for (i = 0; i < 30; i++) begin
				m = (m * m) >> 30;
				frac <<= 1;
				if (m >= (64'd1 << 31)) begin
					m >>= 1;
					frac |= 1;
				end
			end
			nl2 = (longint'(24 - k) << 30) - frac;
			nln = (nl2 * 64'd186065280) >> 28;
			tan2 = ((longint'(rough) * longint'(rough)) * (nln >> 14)) >> 16;
			c2 = (64'd1 << 60) / ((64'd1 << 24) + tan2);
			yq = isqrt(c2 << 24);
			sq = isqrt(((64'd1 << 36) - c2) << 24);
		end else begin
			yq = u << 6;
			sq = isqrt((64'd1 << 60) - yq * yq);
		end
		q = t[23:22];
		r = t & 64'h3FFFFF;
		z = longint'((r * 64'd6746518852) >> 24);
		x = 652032874;
		y = 0;
		for (i = 0; i < 30; i++) begin
			a = (i < 10) ? longint'(atan_q30(i)) : (longint'(1) << (30 - i));
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= a;
			end else begin
				x += dx; y -= dy; z += a;
			end
		end
		case (q)
			2'd0: begin cphi = x;  sphi = y;  end
			2'd1: begin cphi = -y; sphi = x;  end
			2'd2: begin cphi = -x; sphi = -y; end
			default: begin cphi = y; sphi = -x; end
		endcase
		d.dir_x = sat16((longint'(sq) * cphi + (longint'(1) << 44)) >>> 45);
		d.dir_y = sat16(longint'((yq + (64'd1 << 14)) >> 15));
		d.dir_z = sat16((longint'(sq) * sphi + (longint'(1) << 44)) >>> 45);
		return d;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap(bit quiet);
		int p;
		if (quiet)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		int p;
		p = $urandom_range(0, 99);
		s.mode = (p < 6) ? MODE_SPARE : 2'($urandom_range(0, 2));
		p = $urandom_range(0, 99);
		if (p < 10)
			s.u_first = 16'($urandom_range(0, 3));
		else if (p < 15)
			s.u_first = 16'hFFFF - 16'($urandom_range(0, 3));
		else if (p < 30)
			s.u_first = 16'($urandom_range(0, 255));
		else
			s.u_first = 16'($urandom);
		s.u_second = 16'($urandom);
		return s;
	endfunction

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample       <= '0;
			send_gap     <= 0;
		end else begin
			if (sample_valid && !sample_stall)
				expected_dir_q.push_back(predict_direction(sample, rough_model));
			if (sample_valid && sample_stall) begin
				// hold the stalled transaction
			end else if (send_gap > 0) begin
				send_gap     <= send_gap - 1;
				sample_valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				sample       <= pending_q.pop_front();
				sample_valid <= 1'b1;
				send_gap     <= pick_gap(calm);
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// roughness writer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid    <= 1'b0;
			cfg_data     <= '0;
			rough_model  <= ROUGH_RESET;
			rough_writes <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rough_model  <= cfg_data;
				rough_writes <= rough_writes + 1;
			end
			if (cfg_valid && !cfg_ready) begin
				// keep presenting
			end else if (rough_write_q.size() != 0) begin
				cfg_data  <= rough_write_q.pop_front();
				cfg_valid <= 1'b1;
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	// direction monitor
	always @(posedge clk or negedge arst_n) begin
		direction_t exp_dir;
		if (!arst_n) begin
			direction_stall <= 1'b0;
			stall_left      <= 0;
		end else begin
			if (direction_valid && !direction_stall) begin
				if (expected_dir_q.size() == 0) begin
					$display("%0t unexpected direction transaction %h", $time, direction);
					errors++;
				end else begin
					exp_dir = expected_dir_q.pop_front();
					if (direction.dir_x !== exp_dir.dir_x) begin
						$display("%0t dir_x expected %0d actual %0d", $time,
							exp_dir.dir_x, direction.dir_x);
						errors++;
					end
					if (direction.dir_y !== exp_dir.dir_y) begin
						$display("%0t dir_y expected %0d actual %0d", $time,
							exp_dir.dir_y, direction.dir_y);
						errors++;
					end
					if (direction.dir_z !== exp_dir.dir_z) begin
						$display("%0t dir_z expected %0d actual %0d", $time,
							exp_dir.dir_z, direction.dir_z);
						errors++;
					end
				end
			end
			// mostly short stalls, now and then a long one
			if (calm) begin
				direction_stall <= 1'b0;
				stall_left      <= 0;
			end else if (stall_left > 0) begin
				direction_stall <= 1'b1;
				stall_left      <= stall_left - 1;
			end else if ($urandom_range(0, 99) < 2) begin
				direction_stall <= 1'b1;
				stall_left      <= $urandom_range(10, 40);
			end else begin
				direction_stall <= ($urandom_range(0, 99) < 20);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic drain();
		wait (pending_q.size() == 0 && !sample_valid && expected_dir_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic add_sample(logic [1:0] md, logic [15:0] a, logic [15:0] b);
		sample_t s;
		s.mode     = md;
		s.u_first  = a;
		s.u_second = b;
		pending_q.push_back(s);
	endtask

	logic [15:0] rough_plan[PHASES];

	initial begin
		int target;
		errors       = 0;
		cycles       = 0;
		calm         = 1'b0;
		target       = 0;
		arst_n       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rough_plan[0] = 16'd0;
		rough_plan[1] = 16'hFFFF;
		rough_plan[2] = 16'd4096;
		rough_plan[3] = 16'($urandom);
		rough_plan[4] = 16'd1;
		rough_plan[5] = 16'($urandom_range(0, 8191));
		rough_plan[6] = 16'($urandom);
		rough_plan[7] = 16'd2048;

		// directed: every mode at the sample extremes and quadrant edges
		for (int md = 0; md < 4; md++) begin
			add_sample(2'(md), 16'd0, 16'd0);
			add_sample(2'(md), 16'hFFFF, 16'hFFFF);
			add_sample(2'(md), 16'd1, 16'h4000);
			add_sample(2'(md), 16'h8000, 16'h8000);
			add_sample(2'(md), 16'h5555, 16'hC000);
		end
		add_sample(MODE_BECKMANN, 16'd0, 16'h3FFF);
		add_sample(MODE_UNIFORM, 16'd0, 16'h2000);
		add_sample(MODE_COSINE, 16'hFFFF, 16'hBFFF);
		for (int n = 0; n < PHASE_LEN / 2; n++)
			pending_q.push_back(random_sample());
		// hold off mid phase until every pending direction has come back
		wait (pending_q.size() == 0 && !sample_valid && expected_dir_q.size() == 0);
		for (int n = 0; n < PHASE_LEN / 2; n++)
			pending_q.push_back(random_sample());
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			target++;
			rough_write_q.push_back(rough_plan[ph]);
			wait (rough_writes == target);
			@(posedge clk);
			calm = (ph == 3);
			add_sample(MODE_BECKMANN, 16'd0, 16'd0);
			add_sample(MODE_BECKMANN, 16'hFFFF, 16'h1234);
			for (int n = 0; n < PHASE_LEN; n++)
				pending_q.push_back(random_sample());
			drain();
		end

		if (errors == 0 && expected_dir_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
